// ===== design/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared sizes, codes and types for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  localparam logic FN_ENQ = 1'b0;
  localparam logic FN_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_UNDER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic deq;
  } cell_ctrl_t;

endpackage

// ===== design/ssq_if.sv =====
// ----------------------------------------------------------------------------
// ssq_in_if / ssq_out_if
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
interface ssq_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value;
  logic [31:0] priority_req;

  modport source (output valid, func, value, priority_req, input ready);
  modport sink   (input valid, func, value, priority_req, output ready);
endinterface

interface ssq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_value;
  logic [4:0]  occupancy;

  modport source (output valid, status, out_value, occupancy, input ready);
  modport sink   (input valid, status, out_value, occupancy, output ready);
endinterface

// ===== design/ssq_cell.sv =====
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted row: compares its priority with the incoming one,
// takes the new pair, its left neighbor's pair or its right neighbor's pair.
// ----------------------------------------------------------------------------
module ssq_cell (
  input  logic                          clk,
  input  ssq_pkg::cell_ctrl_t           ctrl,
  input  logic                          occ,
  input  logic                          left_take,
  input  logic signed [ssq_pkg::DATA_W-1:0] left_value,
  input  logic signed [ssq_pkg::DATA_W-1:0] left_prio,
  input  logic signed [ssq_pkg::DATA_W-1:0] right_value,
  input  logic signed [ssq_pkg::DATA_W-1:0] right_prio,
  input  logic signed [ssq_pkg::DATA_W-1:0] new_value,
  input  logic signed [ssq_pkg::DATA_W-1:0] new_prio,
  output logic                          take,
  output logic signed [ssq_pkg::DATA_W-1:0] value,
  output logic signed [ssq_pkg::DATA_W-1:0] prio
);
  import ssq_pkg::*;

  logic signed [DATA_W-1:0] value_r, prio_r;

  // empty slot or strictly larger priority: new pair goes here or to the left
  assign take  = !occ || (prio_r > new_prio);
  assign value = value_r;
  assign prio  = prio_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_take) begin
        value_r <= left_value;
        prio_r  <= left_prio;
      end else if (take) begin
        value_r <= new_value;
        prio_r  <= new_prio;
      end
    end else if (ctrl.deq) begin
      value_r <= right_value;
      prio_r  <= right_prio;
    end
  end

endmodule

// ===== design/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted in a row of cells; smallest priority
// leaves first, equal priorities leave in arrival order.
//
//   channel  dir  fields                            handshake
//   in_ch    in   func, value, priority_req         valid/ready
//   out_ch   out  status, out_value, occupancy      valid/ready
//
// one word per cycle: every cell compares against the new priority at once
// and the row shifts by one slot in the cycle the word is accepted
// result is registered in an output register and appears in the cycle after acceptance
// in_ch.ready is low while a result waits and out_ch.ready is low
// rst_n (synchronous) empties the queue; slot contents are not cleared
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
  input  logic    clk,
  input  logic    rst_n,
  ssq_in_if.sink  in_ch,
  ssq_out_if.source out_ch
);
  import ssq_pkg::*;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [CNT_W-1:0]   occ_r;

  logic               fire, full, empty;
  cell_ctrl_t         ctrl;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   take;
  logic signed [DATA_W-1:0] cval [DEPTH];
  logic signed [DATA_W-1:0] cpri [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire  = in_ch.valid && in_ch.ready;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign ctrl.ins = fire && (in_ch.func == FN_ENQ) && !full;
  assign ctrl.deq = fire && (in_ch.func == FN_DEQ) && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                     lt;
      logic signed [DATA_W-1:0] lv, lp, rv, rp;
      assign occ[g] = (CNT_W'(g) < count_r);
      if (g == 0) begin : g_first
        assign lt = 1'b0;
        assign lv = '0;
        assign lp = '0;
      end else begin : g_mid
        assign lt = take[g-1];
        assign lv = cval[g-1];
        assign lp = cpri[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rv = '0;
        assign rp = '0;
      end else begin : g_inner
        assign rv = cval[g+1];
        assign rp = cpri[g+1];
      end
      ssq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ[g]),
        .left_take   (lt),
        .left_value  (lv),
        .left_prio   (lp),
        .right_value (rv),
        .right_prio  (rp),
        .new_value   (in_ch.value),
        .new_prio    (in_ch.priority_req),
        .take        (take[g]),
        .value       (cval[g]),
        .prio        (cpri[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    out_value_nxt = '0;
    status_nxt    = ST_ENQ;
    unique case (in_ch.func)
      FN_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ENQ;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FN_DEQ: begin
        if (empty) begin
          status_nxt = ST_UNDER;
        end else begin
          status_nxt    = ST_DEQ;
          out_value_nxt = cval[0];
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: status_nxt = ST_ENQ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r    <= status_nxt;
      out_value_r <= out_value_nxt;
      occ_r       <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.occupancy = OCC_W'(occ_r);

  // word count never exceeds the number of slots
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // head pair never ranks behind the second pair
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cpri[0] <= cpri[1]))
    else $error("row out of order");

  // an accepted word always yields a result next cycle
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted word without result");

  // underflow only reported on an empty queue
  a_under_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_UNDER) |-> (occ_r == '0))
    else $error("underflow with entries held");

  // a full drop leaves the queue full
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (occ_r == CNT_W'(DEPTH)))
    else $error("drop reported below depth");

endmodule

// ===== tb/sv/stable_sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A scoreboard keeps its
// own sorted copy of the queue, predicts status, dequeued value and
// occupancy for every accepted request word, and compares each result word
// in order. Directed words hit underflow, fill, overflow, ties and priority
// extremes. Random bursts then swing the queue between empty and full, with
// random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_tb;
  import ssq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 850;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  value;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

  class ssq_scoreboard;
    logic [DATA_W-1:0]        held_value [DEPTH];
    logic signed [DATA_W-1:0] held_prio  [DEPTH];
    int                       held_count;
    result_t                  expected [$];
    int                       errors;

    function void note_request(logic f, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p);
      result_t r;
      int      pos;
      r.value = '0;
      if (f == FN_ENQ) begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new entry goes behind every entry of equal priority
          pos = 0;
          while (pos < held_count && held_prio[pos] <= $signed(p)) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_prio[i]  = held_prio[i-1];
          end
          held_value[pos] = v;
          held_prio[pos]  = $signed(p);
          held_count++;
          r.status = ST_ENQ;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.value = held_value[0];
          for (int i = 1; i < held_count; i++) begin
            held_value[i-1] = held_value[i];
            held_prio[i-1]  = held_prio[i];
          end
          held_count--;
          r.status = ST_DEQ;
        end
      end
      r.occupancy = OCC_W'(held_count);
      expected.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] s, logic [DATA_W-1:0] v,
                               logic [OCC_W-1:0] o);
      result_t w;
      if (expected.size() == 0) begin
        $error("result word with no request pending: status %0d value %h occupancy %0d",
               s, v, o);
        errors++;
        return;
      end
      w = expected.pop_front();
      if (s !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, s);
        errors++;
      end
      if (v !== w.value) begin
        $error("out_value: expected %h, actual %h", w.value, v);
        errors++;
      end
      if (o !== w.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", w.occupancy, o);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   sender_calm;
  bit   receiver_calm;
  ssq_scoreboard board;

  ssq_in_if  in_ch ();
  ssq_out_if out_ch ();

  stable_sorted_priority_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stable_sorted_priority_queue regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic f, input logic [DATA_W-1:0] v,
                           input logic [DATA_W-1:0] p);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= f;
    in_ch.value        <= v;
    in_ch.priority_req <= p;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(f, v, p);
    @(negedge clk);
  endtask

  // result side
  initial begin
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    receiver_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(0, 8);
      // one long hold-off so the single result register backs up the input
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      board.check_result(out_ch.status, out_ch.out_value, out_ch.occupancy);
      taken++;
      @(negedge clk);
    end
  end

  // request side
  initial begin
    logic [DATA_W-1:0] dir_prio [17] = '{
      32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
      32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h8000_0000,
      32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h8000_0001,
      32'h7fff_fffe, 32'h0000_0000, 32'h0000_0005, 32'h0000_0003,
      32'h0000_0002
    };
    logic [DATA_W-1:0] p;
    logic              f;
    int                sent;
    int                burst;
    int                enq_pct;

    board = new;
    cycle_count = 0;
    sender_calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_ENQ;
    in_ch.value = '0;
    in_ch.priority_req = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // underflow on empty, fill past full, then a few dequeues
    send_word(FN_DEQ, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 17; i++)
      send_word(FN_ENQ, (i == 0) ? 32'hffff_ffff : 32'h0101_0101 * i, dir_prio[i]);
    send_word(FN_DEQ, 32'h0, 32'h0);
    send_word(FN_DEQ, 32'hffff_ffff, 32'hffff_ffff);
    send_word(FN_DEQ, 32'h8000_0000, 32'h7fff_ffff);

    // bursts biased to fill or drain so the queue visits both ends
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 80;
      endcase
      burst = $urandom_range(8, 40);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst; k++) begin
        f = ($urandom_range(0, 99) < enq_pct) ? FN_ENQ : FN_DEQ;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: p = $urandom_range(0, 3);
          5:             p = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          6:             p = -$urandom_range(0, 3);
          default:       p = $urandom();
        endcase
        send_word(f, $urandom(), p);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0)
      $display("stable_sorted_priority_queue regression: pass");
    else
      $display("stable_sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
